@@ hdl/amgr_pkg.sv @@
// Shared constants, types and helper functions of the ambisonic mirror gain ramp.
package amgr_pkg;

    localparam int CHANNELS_DEF = 36;
    localparam int MAX_BLOCK    = 4096;

    localparam int CHAN_W     = 6;
    localparam int SAMPLE_W   = 24;
    localparam int POS_W      = 12;
    localparam int LEN_W      = 13;
    localparam int GAIN_W     = 15;
    localparam int INV_W      = 7;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 15;

    localparam int MAG_W     = 21;
    localparam int G_W       = 22;
    localparam int DIFF_W    = 23;
    localparam int MUL_A_W   = 24;
    localparam int MUL_B_W   = 23;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int DIV_Q_W   = 22;
    localparam int DIV_NUM_W = LEN_W + DIV_Q_W;

    localparam int FRAC_W = 13;
    localparam int UNITY  = 8192;
    localparam int ROUND  = 4096;

    localparam logic [CFG_IDX_W-1:0] REG_X_EVEN = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_ODD  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_EVEN = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_ODD  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Z_EVEN = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Z_ODD  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RING   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT = 4'd7;

    localparam int INV_X_EVEN = 0;
    localparam int INV_X_ODD  = 1;
    localparam int INV_Y_EVEN = 2;
    localparam int INV_Y_ODD  = 3;
    localparam int INV_Z_EVEN = 4;
    localparam int INV_Z_ODD  = 5;
    localparam int INV_RING   = 6;

    typedef logic signed [G_W-1:0] t_gain;

    // The order of an ACN channel is the count of squares k*k, k >= 1, not above it.
    function automatic logic [2:0] acn_order(input logic [CHAN_W-1:0] chan);
        logic [2:0] ord;
        ord = 3'd0;
        for (int k = 1; k < 8; k++) begin
            if (32'(chan) >= k * k) begin
                ord = ord + 3'd1;
            end
        end
        return ord;
    endfunction

endpackage

@@ hdl/amgr_in_if.sv @@
// Input channel carrying one sample item with its channel and block position.
interface amgr_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [amgr_pkg::CHAN_W-1:0]          chan;
    logic signed [amgr_pkg::SAMPLE_W-1:0] sample_in;
    logic [amgr_pkg::POS_W-1:0]           position;
    logic [amgr_pkg::LEN_W-1:0]           block_len;

    modport source (output valid, chan, sample_in, position, block_len, input ready);
    modport sink (input valid, chan, sample_in, position, block_len, output ready);
endinterface

@@ hdl/amgr_out_if.sv @@
// Output channel carrying one scaled sample item with its channel.
interface amgr_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [amgr_pkg::CHAN_W-1:0]          out_chan;
    logic signed [amgr_pkg::SAMPLE_W-1:0] sample_out;

    modport source (output valid, out_chan, sample_out, input ready);
    modport sink (input valid, out_chan, sample_out, output ready);
endinterface

@@ hdl/amgr_cfg_if.sv @@
// Configuration write channel carrying a register index and write data.
interface amgr_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [amgr_pkg::CFG_IDX_W-1:0]    index;
    logic [amgr_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/amgr_mul.sv @@
// Shared signed multiplier with a registered product.
module amgr_mul (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic signed [amgr_pkg::MUL_A_W-1:0]   i_a,
    input  logic signed [amgr_pkg::MUL_B_W-1:0]   i_b,
    output logic signed [amgr_pkg::PROD_W-1:0]    o_prod
);

    logic signed [amgr_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;

endmodule

@@ hdl/amgr_div.sv @@
// Iterative unsigned divider that resolves two quotient bits per cycle.
module amgr_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [amgr_pkg::DIV_NUM_W-1:0]       i_num,
    input  logic [amgr_pkg::LEN_W-1:0]           i_den,
    output logic                                 o_done,
    output logic [amgr_pkg::DIV_Q_W-1:0]         o_quot
);

    localparam int QW    = amgr_pkg::DIV_Q_W;
    localparam int LW    = amgr_pkg::LEN_W;
    localparam int STEPS = QW / 2;
    localparam int CNT_W = $clog2(STEPS);

    logic [LW-1:0]    r_rem, r_den;
    logic [QW-1:0]    r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;

    logic [LW:0]   w_sh1, w_sh2;
    logic          w_ge1, w_ge2;
    logic [LW-1:0] w_rem1, w_rem2;
    logic [QW-1:0] w_q1, w_q2;

    always_comb begin
        w_sh1  = {r_rem, r_q[QW-1]};
        w_ge1  = w_sh1 >= {1'b0, r_den};
        w_rem1 = w_ge1 ? LW'(w_sh1 - {1'b0, r_den}) : w_sh1[LW-1:0];
        w_q1   = {r_q[QW-2:0], w_ge1};
        w_sh2  = {w_rem1, w_q1[QW-1]};
        w_ge2  = w_sh2 >= {1'b0, r_den};
        w_rem2 = w_ge2 ? LW'(w_sh2 - {1'b0, r_den}) : w_sh2[LW-1:0];
        w_q2   = {w_q1[QW-2:0], w_ge2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[amgr_pkg::DIV_NUM_W-1 -: LW];
            r_q   <= i_num[QW-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_rem2;
            r_q   <= w_q2;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

@@ hdl/amgr_gain_mem.sv @@
// Per-channel store of the previous block gain, reading unity until written.
module amgr_gain_mem #(
    parameter int CHANNELS = amgr_pkg::CHANNELS_DEF,
    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  logic [IDX_W-1:0]      i_rd_addr,
    input  logic                  i_wr_en,
    input  logic [IDX_W-1:0]      i_wr_addr,
    input  amgr_pkg::t_gain       i_wr_data,
    output amgr_pkg::t_gain       o_rd_data
);

    amgr_pkg::t_gain      r_mem [0:CHANNELS-1];
    amgr_pkg::t_gain      r_rd_data;
    logic [CHANNELS-1:0]  r_vld;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : amgr_pkg::t_gain'(amgr_pkg::UNITY);

endmodule

@@ hdl/ambisonic_mirror_gain_ramp.sv @@
// One item is in work at a time: a new item is accepted only in the idle state, once the
// previous result has entered the output register, which an output stall can hold off.
// The radix-4 divide and the single shared multiplier, used up to six times per item, set
// the length of the work on each item.
// Reset is synchronous and active low: it restores the register defaults, empties the
// output register and marks every channel's previous gain as unity.
module ambisonic_mirror_gain_ramp #(
    parameter int CHANNELS = amgr_pkg::CHANNELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    amgr_in_if.sink     i_in,
    amgr_out_if.source  o_out,
    amgr_cfg_if.sink    i_cfg
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PW    = amgr_pkg::PROD_W;
    localparam int FW    = amgr_pkg::FRAC_W;
    localparam int YW    = PW - FW;
    localparam int SW    = amgr_pkg::SAMPLE_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_GMUL  = 4'd1;
    localparam logic [3:0] S_GACC  = 4'd2;
    localparam logic [3:0] S_TGT   = 4'd3;
    localparam logic [3:0] S_DIFF  = 4'd4;
    localparam logic [3:0] S_RMUL  = 4'd5;
    localparam logic [3:0] S_DIVST = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_SCALE = 4'd8;
    localparam logic [3:0] S_SAT   = 4'd9;

    logic [3:0]                               r_state;
    logic [1:0]                               r_step;
    logic [amgr_pkg::CHAN_W-1:0]              r_chan;
    logic signed [SW-1:0]                     r_sample;
    logic [amgr_pkg::POS_W-1:0]               r_pos;
    logic [amgr_pkg::LEN_W-1:0]               r_len;
    logic                                     r_hit, r_sat, r_upd;
    logic [amgr_pkg::MAG_W-1:0]               r_mag;
    logic                                     r_neg, r_qneg;
    amgr_pkg::t_gain                          r_tgt, r_g;
    logic signed [amgr_pkg::DIFF_W-1:0]       r_diff;
    logic                                     r_out_valid;
    logic [amgr_pkg::CHAN_W-1:0]              r_out_chan;
    logic signed [SW-1:0]                     r_out_sample;

    logic [amgr_pkg::GAIN_W-1:0] r_x_even, r_x_odd, r_y_even, r_y_odd;
    logic [amgr_pkg::GAIN_W-1:0] r_z_even, r_z_odd, r_ring;
    logic [amgr_pkg::INV_W-1:0]  r_inv;

    logic                                 w_in_acc;
    logic [amgr_pkg::LEN_W-1:0]           w_len;
    logic                                 w_hit;
    logic [2:0]                           w_l;
    logic [7:0]                           w_mt;
    logic signed [4:0]                    w_m;
    logic                                 w_mneg, w_ring, w_last;
    logic [3:0]                           w_am;
    logic [amgr_pkg::GAIN_W-1:0]          w_f;
    logic                                 w_invb;
    logic                                 w_mul_en;
    logic signed [amgr_pkg::MUL_A_W-1:0]  w_mul_a;
    logic signed [amgr_pkg::MUL_B_W-1:0]  w_mul_b;
    logic signed [PW-1:0]                 w_prod, w_rnd, w_pabs;
    logic signed [YW-1:0]                 w_y;
    logic signed [SW-1:0]                 w_ysat;
    amgr_pkg::t_gain                      w_prev, w_magx;
    logic signed [amgr_pkg::DIFF_W-1:0]   w_qx, w_qs, w_gsum;
    logic                                 w_div_start, w_div_done;
    logic [amgr_pkg::DIV_Q_W-1:0]         w_quot;
    logic                                 w_mem_we, w_out_free;

    assign w_in_acc    = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid      = r_out_valid;
    assign o_out.out_chan   = r_out_chan;
    assign o_out.sample_out = r_out_sample;

    always_comb begin
        w_len = i_in.block_len;
        if (w_len == '0) begin
            w_len = amgr_pkg::LEN_W'(1);
        end else if (32'(w_len) > amgr_pkg::MAX_BLOCK) begin
            w_len = amgr_pkg::LEN_W'(amgr_pkg::MAX_BLOCK);
        end
        w_hit = 32'(i_in.chan) < CHANNELS;
    end

    always_comb begin
        w_l    = amgr_pkg::acn_order(r_chan);
        w_mt   = {2'b00, r_chan} - ({5'b0, w_l} * {5'b0, w_l}) - {5'b0, w_l};
        w_m    = $signed(w_mt[4:0]);
        w_mneg = w_m[4];
        w_am   = w_mneg ? 4'(-w_m) : w_m[3:0];
        w_ring = (w_am == {1'b0, w_l});
        w_last = (r_step == 2'd3) || ((r_step == 2'd2) && !w_ring);
    end

    always_comb begin
        case (r_step)
            2'd0: begin
                if (w_l[0] ^ w_am[0]) begin
                    w_f    = r_z_odd;
                    w_invb = r_inv[amgr_pkg::INV_Z_ODD];
                end else begin
                    w_f    = r_z_even;
                    w_invb = r_inv[amgr_pkg::INV_Z_EVEN];
                end
            end
            2'd1: begin
                if (w_mneg) begin
                    w_f    = r_y_odd;
                    w_invb = r_inv[amgr_pkg::INV_Y_ODD];
                end else begin
                    w_f    = r_y_even;
                    w_invb = r_inv[amgr_pkg::INV_Y_EVEN];
                end
            end
            2'd2: begin
                if (w_mneg == w_am[0]) begin
                    w_f    = r_x_even;
                    w_invb = r_inv[amgr_pkg::INV_X_EVEN];
                end else begin
                    w_f    = r_x_odd;
                    w_invb = r_inv[amgr_pkg::INV_X_ODD];
                end
            end
            default: begin
                w_f    = r_ring;
                w_invb = r_inv[amgr_pkg::INV_RING];
            end
        endcase
    end

    always_comb begin
        w_mul_en = 1'b1;
        w_mul_a  = '0;
        w_mul_b  = '0;
        unique case (r_state)
            S_GMUL: begin
                w_mul_a = $signed({3'b000, r_mag});
                w_mul_b = $signed({8'b0, w_f});
            end
            S_RMUL: begin
                w_mul_a = $signed({12'b0, r_pos});
                w_mul_b = r_diff;
            end
            S_SCALE: begin
                w_mul_a = r_sample;
                w_mul_b = {r_g[amgr_pkg::G_W-1], r_g};
            end
            default: begin
                w_mul_en = 1'b0;
            end
        endcase
    end

    amgr_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    always_comb begin
        w_rnd  = w_prod + PW'(amgr_pkg::ROUND);
        w_pabs = w_prod[PW-1] ? -w_prod : w_prod;
        w_y    = w_rnd[PW-1:FW];
        if (w_y[YW-1:SW-1] == '0 || w_y[YW-1:SW-1] == '1) begin
            w_ysat = w_y[SW-1:0];
        end else if (w_y[YW-1]) begin
            w_ysat = {1'b1, {(SW - 1){1'b0}}};
        end else begin
            w_ysat = {1'b0, {(SW - 1){1'b1}}};
        end
        w_magx = $signed({1'b0, r_mag});
        w_qx   = $signed({1'b0, w_quot});
        w_qs   = r_qneg ? -w_qx : w_qx;
        w_gsum = {w_prev[amgr_pkg::G_W-1], w_prev} + w_qs;
    end

    assign w_div_start = (r_state == S_DIVST);

    amgr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_pabs[amgr_pkg::DIV_NUM_W-1:0]),
        .i_den   (r_len),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_mem_we = (r_state == S_SCALE) && r_hit && r_upd;

    amgr_gain_mem #(
        .CHANNELS (CHANNELS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_in_acc && w_hit),
        .i_rd_addr (IDX_W'(i_in.chan)),
        .i_wr_en   (w_mem_we),
        .i_wr_addr (IDX_W'(r_chan)),
        .i_wr_data (r_tgt),
        .o_rd_data (w_prev)
    );

    assign w_out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_SAT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_step  <= 2'd0;
                        r_state <= w_hit ? S_GMUL : S_SCALE;
                    end
                end
                S_GMUL: r_state <= S_GACC;
                S_GACC: begin
                    if (w_last) begin
                        r_state <= S_TGT;
                    end else begin
                        r_step  <= r_step + 2'd1;
                        r_state <= S_GMUL;
                    end
                end
                S_TGT:   r_state <= S_DIFF;
                S_DIFF:  r_state <= r_sat ? S_SCALE : S_RMUL;
                S_RMUL:  r_state <= S_DIVST;
                S_DIVST: r_state <= S_DIV;
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: r_state <= S_SAT;
                S_SAT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_chan   <= i_in.chan;
                    r_sample <= i_in.sample_in;
                    r_pos    <= i_in.position;
                    r_len    <= w_len;
                    r_hit    <= w_hit;
                    r_sat    <= {1'b0, i_in.position} >= w_len;
                    r_upd    <= ({1'b0, i_in.position} + amgr_pkg::LEN_W'(1)) >= w_len;
                    r_mag    <= amgr_pkg::MAG_W'(amgr_pkg::UNITY);
                    r_neg    <= 1'b0;
                    r_g      <= amgr_pkg::t_gain'(amgr_pkg::UNITY);
                end
            end
            S_GMUL: r_neg <= r_neg ^ w_invb;
            S_GACC: r_mag <= w_rnd[FW +: amgr_pkg::MAG_W];
            S_TGT:  r_tgt <= r_neg ? -w_magx : w_magx;
            S_DIFF: begin
                r_diff <= {r_tgt[amgr_pkg::G_W-1], r_tgt} - {w_prev[amgr_pkg::G_W-1], w_prev};
                if (r_sat) begin
                    r_g <= r_tgt;
                end
            end
            S_DIVST: r_qneg <= w_prod[PW-1];
            S_DIV: begin
                if (w_div_done) begin
                    r_g <= w_gsum[amgr_pkg::G_W-1:0];
                end
            end
            S_SAT: begin
                if (w_out_free) begin
                    r_out_chan   <= r_chan;
                    r_out_sample <= w_ysat;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_even <= amgr_pkg::GAIN_W'(amgr_pkg::UNITY);
            r_x_odd  <= amgr_pkg::GAIN_W'(amgr_pkg::UNITY);
            r_y_even <= amgr_pkg::GAIN_W'(amgr_pkg::UNITY);
            r_y_odd  <= amgr_pkg::GAIN_W'(amgr_pkg::UNITY);
            r_z_even <= amgr_pkg::GAIN_W'(amgr_pkg::UNITY);
            r_z_odd  <= amgr_pkg::GAIN_W'(amgr_pkg::UNITY);
            r_ring   <= amgr_pkg::GAIN_W'(amgr_pkg::UNITY);
            r_inv    <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                amgr_pkg::REG_X_EVEN: r_x_even <= i_cfg.data;
                amgr_pkg::REG_X_ODD:  r_x_odd  <= i_cfg.data;
                amgr_pkg::REG_Y_EVEN: r_y_even <= i_cfg.data;
                amgr_pkg::REG_Y_ODD:  r_y_odd  <= i_cfg.data;
                amgr_pkg::REG_Z_EVEN: r_z_even <= i_cfg.data;
                amgr_pkg::REG_Z_ODD:  r_z_odd  <= i_cfg.data;
                amgr_pkg::REG_RING:   r_ring   <= i_cfg.data;
                amgr_pkg::REG_INVERT: r_inv    <= i_cfg.data[amgr_pkg::INV_W-1:0];
                default: begin
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("Input accepted while the previous item was still in work.");

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("Divider finished outside the divide wait state.");

    a_out_from_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_SAT))
        else $error("Output item appeared without a saturation step.");

    a_mem_write_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |=> !w_mem_we)
        else $error("Gain store written twice for one item.");
`endif

endmodule

@@ tb/sv/amgr_sample_checker.sv @@
`timescale 1ns / 100ps
// Sample checker for the mirror gain ramp: predicts each scaled sample and compares it.
module amgr_sample_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    amgr_in_if   i_in_mon,
    amgr_out_if  i_out_mon,
    amgr_cfg_if  i_cfg_mon,
    output int   o_fail_count,
    output int   o_pending
);
    import amgr_pkg::*;

    localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint SAT_LO = -(longint'(1) <<< (SAMPLE_W - 1));

    typedef struct {
        logic [CHAN_W-1:0]          chan;
        logic signed [SAMPLE_W-1:0] sample;
    } t_scaled_item;

    logic [GAIN_W-1:0] class_gain [7];
    logic [INV_W-1:0]  invert_bits;
    t_gain             block_start_gain [CHANNELS_DEF];
    t_scaled_item      expected_samples [$];
    int                fail_total = 0;

    assign o_fail_count = fail_total;

    function automatic longint q13_mul(input longint mag, input logic [GAIN_W-1:0] factor);
        return (mag * longint'(factor) + ROUND) >>> FRAC_W;
    endfunction

    task automatic flag_failure(input string what);
        fail_total++;
        if (fail_total <= 10) begin
            $display("%s", what);
        end
    endtask

    always @(posedge i_clk) begin : watch
        int           chan_val;
        int           ord;
        int           deg;
        int           adeg;
        int           span;
        int           pos;
        longint       mag;
        longint       ramp;
        longint       scaled;
        bit           flip;
        t_gain        goal;
        t_gain        start;
        t_scaled_item want;
        if (!i_rst_n) begin
            for (int k = 0; k < 7; k++) begin
                class_gain[k] = GAIN_W'(UNITY);
            end
            invert_bits = '0;
            for (int k = 0; k < CHANNELS_DEF; k++) begin
                block_start_gain[k] = t_gain'(UNITY);
            end
            expected_samples.delete();
        end else begin
            if (i_cfg_mon.valid && i_cfg_mon.ready) begin
                if (i_cfg_mon.index < REG_INVERT) begin
                    class_gain[i_cfg_mon.index[2:0]] = i_cfg_mon.data;
                end else if (i_cfg_mon.index == REG_INVERT) begin
                    invert_bits = i_cfg_mon.data[INV_W-1:0];
                end
            end

            if (i_out_mon.valid && i_out_mon.ready) begin
                if (expected_samples.size() == 0) begin
                    flag_failure($sformatf("unexpected item: chan %0d sample %0d",
                                           i_out_mon.out_chan, i_out_mon.sample_out));
                end else begin
                    want = expected_samples.pop_front();
                    if (want.chan !== i_out_mon.out_chan ||
                        want.sample !== i_out_mon.sample_out) begin
                        flag_failure($sformatf(
                            "mismatch: expected chan %0d sample %0d, got chan %0d sample %0d",
                            want.chan, want.sample, i_out_mon.out_chan,
                            i_out_mon.sample_out));
                    end
                end
            end

            if (i_in_mon.valid && i_in_mon.ready) begin
                chan_val = int'(i_in_mon.chan);
                pos      = int'(i_in_mon.position);
                span     = int'(i_in_mon.block_len);
                if (span == 0) begin
                    span = 1;
                end
                if (span > MAX_BLOCK) begin
                    span = MAX_BLOCK;
                end
                if (chan_val < CHANNELS_DEF) begin
                    ord = 0;
                    while ((ord + 1) * (ord + 1) <= chan_val) begin
                        ord++;
                    end
                    deg  = chan_val - ord * ord - ord;
                    adeg = (deg < 0) ? -deg : deg;
                    mag  = UNITY;
                    flip = 1'b0;
                    // Class gains are applied in the order z, y, x, ring.
                    if (((ord + adeg) % 2) == 0) begin
                        mag  = q13_mul(mag, class_gain[REG_Z_EVEN[2:0]]);
                        flip = flip ^ invert_bits[INV_Z_EVEN];
                    end else begin
                        mag  = q13_mul(mag, class_gain[REG_Z_ODD[2:0]]);
                        flip = flip ^ invert_bits[INV_Z_ODD];
                    end
                    if (deg >= 0) begin
                        mag  = q13_mul(mag, class_gain[REG_Y_EVEN[2:0]]);
                        flip = flip ^ invert_bits[INV_Y_EVEN];
                    end else begin
                        mag  = q13_mul(mag, class_gain[REG_Y_ODD[2:0]]);
                        flip = flip ^ invert_bits[INV_Y_ODD];
                    end
                    if ((deg >= 0) == ((adeg % 2) == 0)) begin
                        mag  = q13_mul(mag, class_gain[REG_X_EVEN[2:0]]);
                        flip = flip ^ invert_bits[INV_X_EVEN];
                    end else begin
                        mag  = q13_mul(mag, class_gain[REG_X_ODD[2:0]]);
                        flip = flip ^ invert_bits[INV_X_ODD];
                    end
                    if (adeg == ord) begin
                        mag  = q13_mul(mag, class_gain[REG_RING[2:0]]);
                        flip = flip ^ invert_bits[INV_RING];
                    end
                    goal  = t_gain'(flip ? -mag : mag);
                    start = block_start_gain[chan_val];
                    if (pos >= span) begin
                        ramp = goal;
                    end else begin
                        ramp = start + ((longint'(goal) - longint'(start)) * pos) / span;
                    end
                    if (pos + 1 >= span) begin
                        block_start_gain[chan_val] = goal;
                    end
                end else begin
                    ramp = UNITY;
                end
                scaled = (longint'(i_in_mon.sample_in) * ramp + ROUND) >>> FRAC_W;
                if (scaled > SAT_HI) begin
                    scaled = SAT_HI;
                end
                if (scaled < SAT_LO) begin
                    scaled = SAT_LO;
                end
                want.chan   = i_in_mon.chan;
                want.sample = SAMPLE_W'(scaled);
                expected_samples.push_back(want);
            end
        end
        o_pending <= expected_samples.size();
    end
endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Testbench top: drives samples and register writes into the mirror gain ramp and reports.
module tb;
    import amgr_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASES      = 9;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    bit   tail_phase = 1'b0;
    bit   hold_request = 1'b0;

    logic [GAIN_W-1:0] plan_gain [7];
    logic [INV_W-1:0]  plan_invert;

    amgr_in_if  in_bus ();
    amgr_out_if out_bus ();
    amgr_cfg_if cfg_bus ();

    ambisonic_mirror_gain_ramp dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    amgr_sample_checker sample_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_mon     (in_bus),
        .i_out_mon    (out_bus),
        .i_cfg_mon    (cfg_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ambisonic_mirror_gain_ramp verification failed");
            $finish;
        end
    end

    // The output side stalls in short random bursts, and once for a long stretch on request.
    initial begin : sink_side
        int stretch;
        out_bus.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                out_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (!tail_phase && $urandom_range(0, 3) == 0) begin
                out_bus.ready <= 1'b0;
                stretch = $urandom_range(1, 9);
                repeat (stretch) @(posedge clk);
            end else begin
                out_bus.ready <= 1'b1;
                stretch = $urandom_range(1, 24);
                repeat (stretch) @(posedge clk);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge clk iff cfg_bus.ready);
    endtask

    task automatic plan_settings(input int phase);
        for (int k = 0; k < 7; k++) begin
            case (phase)
                0: plan_gain[k] = GAIN_W'(4096 + 3500 * k);
                1: plan_gain[k] = '1;
                2: plan_gain[k] = '0;
                3: plan_gain[k] = GAIN_W'(UNITY);
                default: begin
                    if ($urandom_range(0, 1) == 0) begin
                        plan_gain[k] = GAIN_W'($urandom_range(0, 32767));
                    end else begin
                        plan_gain[k] = GAIN_W'($urandom_range(6000, 11000));
                    end
                end
            endcase
        end
        case (phase)
            0: plan_invert = 7'h55;
            1: plan_invert = '1;
            2: plan_invert = '0;
            3: plan_invert = '0;
            default: plan_invert = INV_W'($urandom_range(0, 127));
        endcase
    endtask

    task automatic load_settings();
        for (int k = 0; k < 7; k++) begin
            write_reg(REG_X_EVEN + CFG_IDX_W'(k), plan_gain[k]);
        end
        write_reg(REG_INVERT + CFG_IDX_W'($urandom_range(1, 8)), CFG_DATA_W'($urandom));
        write_reg(REG_INVERT, {8'($urandom), plan_invert});
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic send_sample(input logic [CHAN_W-1:0] chan,
                               input logic signed [SAMPLE_W-1:0] sample,
                               input logic [POS_W-1:0] pos,
                               input logic [LEN_W-1:0] span);
        int gap;
        if (!tail_phase && $urandom_range(0, 4) == 0) begin
            in_bus.valid <= 1'b0;
            gap = $urandom_range(1, 9);
            repeat (gap) @(posedge clk);
        end
        in_bus.valid     <= 1'b1;
        in_bus.chan      <= chan;
        in_bus.sample_in <= sample;
        in_bus.position  <= pos;
        in_bus.block_len <= span;
        @(posedge clk iff in_bus.ready);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return SAMPLE_W'($urandom_range(0, 512)) - SAMPLE_W'(256);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic directed_items();
        send_sample(6'd0, SAMPLE_MAX, 12'd0, 13'd4);
        send_sample(6'd0, SAMPLE_MIN, 12'd2, 13'd4);
        send_sample(6'd0, 24'sd12345, 12'd3, 13'd4);
        send_sample(6'd0, -24'sd1, 12'd1, 13'd4);
        send_sample(6'd35, SAMPLE_MAX, 12'd4095, 13'd4096);
        send_sample(6'd35, SAMPLE_MIN, 12'd4095, 13'd8191);
        send_sample(6'd36, SAMPLE_MAX, 12'd7, 13'd3);
        send_sample(6'd63, SAMPLE_MIN, 12'd0, 13'd0);
        send_sample(6'd1, 24'sd0, 12'd0, 13'd0);
        send_sample(6'd2, 24'sd1000, 12'd4095, 13'd1);
        send_sample(6'd3, -24'sd1000, 12'd4095, 13'd4097);
        send_sample(6'd9, 24'sd777777, 12'd100, 13'd8191);
        for (int c = 4; c < 16; c++) begin
            send_sample(CHAN_W'(c), (c % 2 == 0) ? SAMPLE_W'(c * 350001) : -SAMPLE_W'(c * 350001),
                        12'd1, 13'd2);
        end
    endtask

    // Mostly blocks walked in order over a few channels, plus stray and noisy items.
    task automatic random_traffic(input int count);
        int                sent;
        int                span;
        int                lanes;
        int                pick;
        logic [CHAN_W-1:0] lane_chan [3];
        int                steps [$];
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    span = $urandom_range(1, 6);
                end else if (pick < 9) begin
                    span = $urandom_range(7, 64);
                end else begin
                    span = $urandom_range(65, MAX_BLOCK);
                end
                lanes = $urandom_range(1, 3);
                for (int k = 0; k < lanes; k++) begin
                    lane_chan[k] = CHAN_W'($urandom_range(0, CHANNELS_DEF - 1));
                end
                steps.delete();
                if (span <= 8) begin
                    for (int p = 0; p < span; p++) begin
                        steps.push_back(p);
                    end
                end else begin
                    steps.push_back(0);
                    steps.push_back($urandom_range(1, span - 2));
                    steps.push_back(span - 1);
                end
                foreach (steps[s]) begin
                    for (int k = 0; k < lanes; k++) begin
                        send_sample(lane_chan[k], pick_sample(), POS_W'(steps[s]),
                                    LEN_W'(span));
                        sent++;
                    end
                end
            end else if (pick < 90) begin
                send_sample(CHAN_W'($urandom_range(0, CHANNELS_DEF - 1)), pick_sample(),
                            POS_W'($urandom_range(0, MAX_BLOCK - 1)),
                            LEN_W'($urandom_range(1, MAX_BLOCK)));
                sent++;
            end else begin
                send_sample(CHAN_W'($urandom), pick_sample(), POS_W'($urandom),
                            LEN_W'($urandom));
                sent++;
            end
        end
    endtask

    task automatic wait_idle();
        do begin
            @(posedge clk);
        end while (pending != 0);
    endtask

    initial begin : stimulus
        in_bus.valid     <= 1'b0;
        in_bus.chan      <= '0;
        in_bus.sample_in <= '0;
        in_bus.position  <= '0;
        in_bus.block_len <= '0;
        cfg_bus.valid    <= 1'b0;
        cfg_bus.index    <= '0;
        cfg_bus.data     <= '0;
        rst_n            <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int phase = 0; phase < PHASES; phase++) begin
            plan_settings(phase);
            load_settings();
            if (phase == 0) begin
                directed_items();
            end
            if (phase == 3) begin
                hold_request = 1'b1;
            end
            if (phase == PHASES - 1) begin
                tail_phase = 1'b1;
            end
            random_traffic((phase == 0) ? 80 : 100);
            in_bus.valid <= 1'b0;
            wait_idle();
        end
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ambisonic_mirror_gain_ramp verification clean");
        end else begin
            $display("ambisonic_mirror_gain_ramp verification failed");
        end
        $finish;
    end
endmodule
